@@ design/cccd_pkg.sv @@
package cccd_pkg;

  localparam int unsigned DEF_MAX_SET_BITS  = 64;
  localparam int unsigned DEF_MAX_POSITIONS = 64;

  typedef enum logic {
    ACT_RANK   = 1'b0,
    ACT_UNRANK = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_ARGS   = 2'd1,
    STAT_RANK_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic        carry;
    logic [63:0] sum;
  } alu_res_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_CHECK_RD,
    ST_CHECK,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        action;
    logic [63:0] value;
    logic [6:0]  positions;
    logic [6:0]  set_count;
  } req_t;

  typedef struct packed {
    logic [63:0] result;
    logic [1:0]  status;
  } rsp_t;

endpackage

@@ design/cccd_ram.sv @@
module cccd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4225
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ design/cccd_alu.sv @@
module cccd_alu
  import cccd_pkg::*;
(
  input  alu_op_t     op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output alu_res_t    res
);

  logic [63:0] b_eff;

  assign b_eff = (op == ALU_SUB) ? ~b : b;

  // For subtraction the carry out is set when a >= b.
  assign {res.carry, res.sum} = {1'b0, a} + {1'b0, b_eff} + {64'd0, (op == ALU_SUB)};

endmodule

@@ design/cccd_tbl_init.sv @@
module cccd_tbl_init
  import cccd_pkg::*;
#(
  parameter int MAX_SET_BITS  = DEF_MAX_SET_BITS,
  parameter int MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic                                                      clk,
  input  logic                                                      rst,
  input  logic [63:0]                                               sum,
  output logic                                                      busy,
  output logic                                                      we,
  output logic [$clog2((MAX_POSITIONS+1)*(MAX_SET_BITS+1))-1:0]     waddr,
  output logic [63:0]                                               wdata,
  output logic [$clog2((MAX_POSITIONS+1)*(MAX_SET_BITS+1))-1:0]     raddr,
  output logic [63:0]                                               prev
);

  localparam int ROWS = MAX_POSITIONS + 1;
  localparam int COLS = MAX_SET_BITS + 1;
  localparam int AW   = $clog2(ROWS * COLS);

  logic [6:0] p;
  logic [6:0] j;

  function automatic logic [AW-1:0] tbl_addr(input logic [6:0] row, input logic [6:0] col);
    return AW'(int'(row) * COLS + int'(col));
  endfunction

  // The table is built one column at a time with Pascal's rule. The entry one
  // row up in the previous column is read in the cycle before its use, and the
  // entry one row up in the current column is the value written last.
  always_comb begin
    if (j == 7'd0) begin
      wdata = 64'd1;
    end else if (p == 7'd0) begin
      wdata = 64'd0;
    end else begin
      wdata = sum;
    end
  end

  assign we    = busy;
  assign waddr = tbl_addr(p, j);
  assign raddr = (j == 7'd0) ? tbl_addr(p, 7'd0) : tbl_addr(p, j - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      p    <= 7'd0;
      j    <= 7'd0;
    end else if (busy) begin
      if (p == 7'(ROWS - 1)) begin
        p <= 7'd0;
        if (j == 7'(COLS - 1)) begin
          busy <= 1'b0;
        end else begin
          j <= j + 7'd1;
        end
      end else begin
        p <= p + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      prev <= wdata;
    end
  end

endmodule

@@ design/combinadic_colex_codec.sv @@
// Colex combinadic rank/unrank engine for k-subsets of n bit positions. After
// reset the block builds its binomial coefficient table, one entry per cycle;
// req_stall stays high during that time. A rank transaction then scans the
// bit positions in turn, and an unrank transaction walks the positions down in
// turn. Both use the single shared 64-bit adder and the coefficient memory.
// Bad arguments go straight to the finish state. A finished result sits in an
// output register, and the block takes a new request while that result waits.
module combinadic_colex_codec
  import cccd_pkg::*;
#(
  parameter int MAX_SET_BITS  = DEF_MAX_SET_BITS,
  parameter int MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int ROWS  = MAX_POSITIONS + 1;
  localparam int COLS  = MAX_SET_BITS + 1;
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  state_t      state, state_next;
  logic [63:0] val, val_next;
  logic [63:0] res, res_next;
  logic [6:0]  n, n_next;
  logic [6:0]  k, k_next;
  logic [6:0]  pos, pos_next;
  logic [6:0]  cnt, cnt_next;
  logic        pend, pend_next;
  logic        sel, sel_next;
  status_t     stat, stat_next;
  logic        load_out;

  logic [6:0]  rda_p, rda_j, rdb_p, rdb_j;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [63:0] rdata_a, rdata_b;
  logic [63:0] walk_coef;
  logic        bad_args;
  logic        scan_stop;

  alu_op_t     alu_op;
  logic [63:0] alu_a, alu_b;
  alu_res_t    alu_out;

  logic          fill_busy;
  logic          fill_we;
  logic [AW-1:0] fill_waddr;
  logic [63:0]   fill_wdata;
  logic [AW-1:0] fill_raddr;
  logic [63:0]   fill_prev;

  function automatic logic [AW-1:0] tbl_addr(input logic [6:0] row, input logic [6:0] col);
    return AW'(int'(row) * COLS + int'(col));
  endfunction

  cccd_tbl_init #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_tbl_init (
    .clk  (clk),
    .rst  (rst),
    .sum  (alu_out.sum),
    .busy (fill_busy),
    .we   (fill_we),
    .waddr(fill_waddr),
    .wdata(fill_wdata),
    .raddr(fill_raddr),
    .prev (fill_prev)
  );

  cccd_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_tbl (
    .clk    (clk),
    .we     (fill_we),
    .waddr  (fill_waddr),
    .wdata  (fill_wdata),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  cccd_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .res(alu_out)
  );

  assign raddr_a = (state == ST_FILL) ? fill_raddr : tbl_addr(rda_p, rda_j);
  assign raddr_b = tbl_addr(rdb_p, rdb_j);

  assign req_stall = (state != ST_IDLE);
  assign walk_coef = sel ? rdata_b : rdata_a;

  assign bad_args = (req_data.positions == 7'd0) ||
                    (req_data.positions > 7'(MAX_POSITIONS)) ||
                    (req_data.set_count == 7'd0) ||
                    (req_data.set_count > 7'(MAX_SET_BITS)) ||
                    (req_data.set_count > req_data.positions);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val  <= val_next;
    res  <= res_next;
    n    <= n_next;
    k    <= k_next;
    pos  <= pos_next;
    cnt  <= cnt_next;
    sel  <= sel_next;
    stat <= stat_next;
    if (load_out) begin
      rsp_data.result <= res;
      rsp_data.status <= stat;
    end
  end

  always_comb begin
    state_next = state;
    val_next   = val;
    res_next   = res;
    n_next     = n;
    k_next     = k;
    pos_next   = pos;
    cnt_next   = cnt;
    pend_next  = 1'b0;
    sel_next   = sel;
    stat_next  = stat;
    load_out   = 1'b0;
    scan_stop  = 1'b0;
    rda_p      = 7'd0;
    rda_j      = 7'd0;
    rdb_p      = 7'd0;
    rdb_j      = 7'd0;
    alu_op     = ALU_ADD;
    alu_a      = res;
    alu_b      = rdata_a;

    unique case (state)
      ST_FILL: begin
        alu_a = fill_prev;
        if (!fill_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          val_next  = req_data.value;
          n_next    = req_data.positions;
          k_next    = req_data.set_count;
          res_next  = 64'd0;
          pos_next  = 7'd0;
          cnt_next  = 7'd0;
          stat_next = STAT_OK;
          if (bad_args) begin
            stat_next  = STAT_BAD_ARGS;
            state_next = ST_FINISH;
          end else if (req_data.action == ACT_RANK) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_CHECK_RD;
          end
        end
      end
      ST_SCAN: begin
        // The coefficient fetched for the previous set bit is added here.
        if (pend) begin
          res_next = alu_out.sum;
        end
        if (cnt == k) begin
          scan_stop = 1'b1;
        end else if (val[pos[5:0]]) begin
          if (pos >= n) begin
            scan_stop = 1'b1;
          end else begin
            rda_p     = pos;
            rda_j     = cnt + 7'd1;
            pend_next = 1'b1;
            cnt_next  = cnt + 7'd1;
          end
        end
        if (pos[5:0] == 6'h3f) begin
          scan_stop = 1'b1;
        end
        pos_next = pos + 7'd1;
        if (scan_stop) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend) begin
          res_next = alu_out.sum;
        end
        state_next = ST_FINISH;
      end
      ST_CHECK_RD: begin
        rda_p      = n;
        rda_j      = k;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        alu_op = ALU_SUB;
        alu_a  = val;
        if (alu_out.carry) begin
          stat_next  = STAT_RANK_RANGE;
          state_next = ST_FINISH;
        end else begin
          pos_next   = n - 7'd1;
          rda_p      = n - 7'd1;
          rda_j      = k;
          rdb_p      = n - 7'd1;
          rdb_j      = k - 7'd1;
          sel_next   = 1'b0;
          cnt_next   = k;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        // Both candidate coefficients for the next position are fetched,
        // and the compare result of this position picks one of them.
        alu_op = ALU_SUB;
        alu_a  = val;
        alu_b  = walk_coef;
        if (alu_out.carry) begin
          val_next = alu_out.sum;
          res_next = res | (64'd1 << pos[5:0]);
        end
        cnt_next = cnt - 7'(alu_out.carry);
        sel_next = alu_out.carry;
        if (pos != 7'd0) begin
          rda_p = pos - 7'd1;
          rdb_p = pos - 7'd1;
        end
        rda_j = cnt;
        rdb_j = cnt - 7'd1;
        if (cnt_next == 7'd0 || pos == 7'd0) begin
          state_next = ST_FINISH;
        end else begin
          pos_next = pos - 7'd1;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/cccd_checker.sv @@
module cccd_checker
  import cccd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request port open right after a transaction");

  a_table_build: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall)
    else $error("request port open while the table is built");

  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared without work in progress");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != STAT_OK) |-> rsp_data.result == 64'd0)
    else $error("error response with a nonzero result");

endmodule

bind combinadic_colex_codec cccd_checker u_cccd_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .req_data (req_data),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp_data (rsp_data)
);

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cccd_pkg::*;

  localparam int unsigned N_MAX = DEF_MAX_POSITIONS;
  localparam int unsigned K_MAX = DEF_MAX_SET_BITS;
  localparam int unsigned RANDOM_ITEMS = 925;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SQUEEZE_AT = 300;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  logic [63:0] binom [0:N_MAX][0:K_MAX];
  req_t pending_reqs[$];
  rsp_t expected_codes[$];

  logic req_hs = 1'b0;
  logic rsp_hs = 1'b0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int unsigned squeeze_left = 0;
  bit squeeze_done = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned n_rank = 0;
  int unsigned n_unrank = 0;
  int unsigned n_bad = 0;
  int unsigned n_range = 0;

  combinadic_colex_codec DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic rsp_t colex_code(req_t rq);
    rsp_t r;
    int unsigned n;
    int unsigned k;
    int unsigned found;
    int unsigned left;
    int unsigned pos;
    bit stop;
    logic [63:0] rest;
    logic [63:0] c;
    r.result = '0;
    r.status = STAT_OK;
    n = rq.positions;
    k = rq.set_count;
    if (n == 0 || n > N_MAX || k == 0 || k > K_MAX || k > n) begin
      r.status = STAT_BAD_ARGS;
    end else if (rq.action == ACT_RANK) begin
      found = 0;
      stop = 1'b0;
      for (int p = 0; p < 64; p++) begin
        if (!stop && found < k && rq.value[p]) begin
          if (p >= n) begin
            stop = 1'b1;
          end else begin
            r.result += binom[p][found + 1];
            found++;
          end
        end
      end
    end else if (rq.value >= binom[n][k]) begin
      r.status = STAT_RANK_RANGE;
    end else begin
      rest = rq.value;
      left = k;
      pos = n;
      while (left > 0 && pos > 0) begin
        pos--;
        c = binom[pos][left];
        if (c <= rest) begin
          r.result[pos] = 1'b1;
          rest -= c;
          left--;
        end
      end
    end
    return r;
  endfunction

  function automatic req_t mk_req(action_t act, logic [63:0] v, int unsigned n, int unsigned k);
    req_t rq;
    rq.action = act;
    rq.value = v;
    rq.positions = n[6:0];
    rq.set_count = k[6:0];
    return rq;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pause_len(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    if (calm) return 0;
    return $urandom_range(0, 18);
  endfunction

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [63:0] v;
    logic [63:0] c;
    logic [63:0] mask;
    rsp_t pat;

    for (int p = 0; p <= N_MAX; p++) begin
      for (int j = 0; j <= K_MAX; j++) begin
        if (j == 0) binom[p][j] = 64'd1;
        else if (p == 0 || j > p) binom[p][j] = '0;
        else binom[p][j] = binom[p - 1][j - 1] + binom[p - 1][j];
      end
    end

    pending_reqs.push_back(mk_req(ACT_RANK, '1, 64, 64));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'd1, 1, 1));
    pending_reqs.push_back(mk_req(ACT_RANK, '0, 64, 10));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'h8000_0000_0000_0000, 64, 1));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'h0000_0000_0000_1025, 10, 3));
    pending_reqs.push_back(mk_req(ACT_RANK, '1, 64, 5));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'h0000_0000_0001_0001, 40, 20));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'hFFFF_FFFF_0000_0000, 64, 32));
    pending_reqs.push_back(mk_req(ACT_UNRANK, binom[64][32] - 1, 64, 32));
    pending_reqs.push_back(mk_req(ACT_UNRANK, binom[64][32], 64, 32));
    pending_reqs.push_back(mk_req(ACT_UNRANK, '1, 64, 1));
    pending_reqs.push_back(mk_req(ACT_UNRANK, 64'd63, 64, 1));
    pending_reqs.push_back(mk_req(ACT_UNRANK, '0, 64, 64));
    pending_reqs.push_back(mk_req(ACT_UNRANK, '0, 1, 1));
    pending_reqs.push_back(mk_req(ACT_UNRANK, 64'd1, 1, 1));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'd5, 0, 1));
    pending_reqs.push_back(mk_req(ACT_UNRANK, 64'd0, 0, 1));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'd5, 65, 3));
    pending_reqs.push_back(mk_req(ACT_UNRANK, 64'd5, 127, 3));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'd5, 10, 0));
    pending_reqs.push_back(mk_req(ACT_UNRANK, 64'd0, 64, 65));
    pending_reqs.push_back(mk_req(ACT_RANK, '1, 127, 127));
    pending_reqs.push_back(mk_req(ACT_RANK, 64'd7, 5, 6));
    pending_reqs.push_back(mk_req(ACT_UNRANK, 64'd0, 5, 6));

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      n = $urandom_range(1, N_MAX);
      k = $urandom_range(1, n);
      c = binom[n][k];
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0: v = c - 1;
          1: v = c;
          default: v = rand64() % c;
        endcase
        pending_reqs.push_back(mk_req(ACT_UNRANK, v, n, k));
      end else if (pick < 75) begin
        mask = (n == 64) ? '1 : ((64'd1 << n) - 1);
        case ($urandom_range(0, 3))
          0: v = rand64();
          1: v = rand64() & mask;
          default: begin
            pat = colex_code(mk_req(ACT_UNRANK, rand64() % c, n, k));
            v = pat.result;
          end
        endcase
        pending_reqs.push_back(mk_req(ACT_RANK, v, n, k));
      end else if (pick < 85) begin
        pending_reqs.push_back(mk_req(ACT_UNRANK, rand64(), n, k));
      end else begin
        pending_reqs.push_back(mk_req(action_t'($urandom_range(0, 1)), rand64(),
                                      $urandom_range(0, 127), $urandom_range(0, 127)));
      end
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d transactions: %0d rank, %0d unrank, %0d bad arguments,",
             n_rank + n_unrank + n_bad + n_range, n_rank, n_unrank, n_bad);
    $display("%0d rank out of range; the receiver held off for %0d cycles once.",
             n_range, SQUEEZE_CYCLES);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_hs) begin
      if (req_hs) send_gap = pause_len(tx_calm);
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req_data <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (!squeeze_done && items_sent >= SQUEEZE_AT) begin
        squeeze_left = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end
      if (rsp_hs) hold_left = pause_len(rx_calm);
      if (squeeze_left > 0) begin
        squeeze_left--;
        rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    rsp_t want_in;
    bit req_fire;
    bit rsp_fire;
    req_fire = !rst && req_valid && !req_stall;
    rsp_fire = !rst && rsp_valid && !rsp_stall;
    req_hs <= req_fire;
    rsp_hs <= rsp_fire;
    if (req_fire) begin
      want_in = colex_code(req_data);
      expected_codes.push_back(want_in);
      items_sent++;
      if (want_in.status == STAT_OK) begin
        if (req_data.action == ACT_RANK) n_rank++;
        else n_unrank++;
      end
    end
    if (rsp_fire) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected result %h status %0d", $realtime, rsp_data.result,
                 rsp_data.status);
        errors++;
      end else begin
        want = expected_codes.pop_front();
        if (rsp_data.result !== want.result) begin
          $display("%0t: result mismatch, expected %h, actual %h", $realtime, want.result,
                   rsp_data.result);
          errors++;
        end
        if (rsp_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $realtime, want.status,
                   rsp_data.status);
          errors++;
        end
        case (want.status)
          STAT_BAD_ARGS: n_bad++;
          STAT_RANK_RANGE: n_range++;
          default: ;
        endcase
      end
    end
    if (rst || req_fire || rsp_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
